[rtl/core/amr_pkg.sv]
// Package: shared constants and types for the refinement tagger.
`default_nettype none
package amr_pkg;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int LEVEL_BITS_DEF = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NDIM     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEGATE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REFINE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEREFINE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAXLEVEL = 3'd5;

  localparam logic [1:0] MODE_FIRST  = 2'd0;
  localparam logic [1:0] MODE_SECOND = 2'd1;

  localparam logic [1:0] TAG_DEREFINE = 2'd0;
  localparam logic [1:0] TAG_SAME     = 2'd1;
  localparam logic [1:0] TAG_REFINE   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_DIV, ST_NEXT, ST_CLASSIFY, ST_OUT
  } amr_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input transaction
    logic prep;      // form numerator/denominator for current axis
    logic div_step;  // one quotient bit
    logic axis_done; // fold quotient into cell measure, advance axis
    logic classify;  // update row peak and block tag
    logic emit;      // clear block tag after output taken
  } amr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_last;
    logic axis_last;
    logic use_div;
    logic block_end;
  } amr_sts_t;
endpackage
`default_nettype wire

[rtl/core/amr_if.sv]
// Interfaces: input cell and result tag channels.
`default_nettype none
interface amr_in_if #(parameter int DW = 32, parameter int LW = 5);
  logic valid, ready;
  logic signed [DW-1:0] center, x_minus, x_plus, y_minus, y_plus, z_minus, z_plus;
  logic var_present, row_last, block_last;
  logic [LW-1:0] block_level;
  modport source(output valid, center, x_minus, x_plus, y_minus, y_plus, z_minus,
                 z_plus, var_present, block_level, row_last, block_last, input ready);
  modport sink(input valid, center, x_minus, x_plus, y_minus, y_plus, z_minus,
               z_plus, var_present, block_level, row_last, block_last, output ready);
endinterface

interface amr_out_if;
  logic valid, ready;
  logic [1:0] tag;
  modport source(output valid, tag, input ready);
  modport sink(input valid, tag, output ready);
endinterface
`default_nettype wire

[rtl/core/amr_refinement_tagger_core.sv]
// Top level: gradient refinement tagger with config registers.
// Each cell transaction is taken when idle. In magnitude mode, or when the
// variable is absent, a cell skips division. In derivative modes each active
// axis runs a bit-serial restoring divider, one quotient bit per cycle, of
// DATA_WIDTH+1+FRAC_BITS steps, between a prep state and an axis-done state.
// Defaults are Q16.16 data in 3D. A block-end cell then holds its tag on the
// output until it is taken.
`default_nettype none
module amr_refinement_tagger_core import amr_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  amr_in_if.sink    in_ch,
  amr_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);
  logic [1:0] mode_r, ndim_r;
  logic neg_r;
  logic signed [DATA_WIDTH-1:0] rt_r, dt_r;
  logic [LEVEL_BITS-1:0] maxl_r;

  // config writes; thresholds take low bits sign-extended
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 2'd0; ndim_r <= 2'd3; neg_r <= 1'b0;
      rt_r <= DATA_WIDTH'(32768); dt_r <= DATA_WIDTH'(3277);
      maxl_r <= LEVEL_BITS'(31);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:     mode_r <= cfg_wdata[1:0];
        REG_NDIM:     ndim_r <= cfg_wdata[1:0];
        REG_NEGATE:   neg_r <= cfg_wdata[0];
        REG_REFINE:   rt_r <= DATA_WIDTH'($signed(cfg_wdata));
        REG_DEREFINE: dt_r <= DATA_WIDTH'($signed(cfg_wdata));
        REG_MAXLEVEL: maxl_r <= LEVEL_BITS'(cfg_wdata[4:0]);
        default: ;
      endcase
    end
  end

  amr_cmd_t cmd;
  amr_sts_t sts;

  amr_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd
  );

  amr_dp #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .LEVEL_BITS(LEVEL_BITS)) u_dp (
    .clk, .rst_n, .in_ch,
    .mode(mode_r), .ndim_used(ndim_r), .negate_magnitude(neg_r),
    .refine_threshold(rt_r), .derefine_threshold(dt_r), .level_cap(maxl_r),
    .cmd, .sts, .tag(out_ch.tag)
  );
endmodule
`default_nettype wire

[rtl/core/amr_ctrl.sv]
// Controller: sequences capture, per-axis division, classification, output.
`default_nettype none
module amr_ctrl import amr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire amr_sts_t sts,
  output amr_cmd_t  cmd
);
  amr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (sts.use_div) begin
          cmd.prep = 1'b1;
          state_nxt = ST_DIV;
        end else state_nxt = ST_CLASSIFY;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        cmd.axis_done = 1'b1;
        state_nxt = sts.axis_last ? ST_CLASSIFY : ST_PREP;
      end
      ST_CLASSIFY: begin
        cmd.classify = 1'b1;
        state_nxt = sts.block_end ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[rtl/core/amr_dp.sv]
// Datapath: operand capture, restoring divider, peak and tag registers.
`default_nettype none
module amr_dp import amr_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  amr_in_if.sink    in_ch,
  input  wire logic [1:0] mode,
  input  wire logic [1:0] ndim_used,
  input  wire logic       negate_magnitude,
  input  wire logic signed [DATA_WIDTH-1:0] refine_threshold,
  input  wire logic signed [DATA_WIDTH-1:0] derefine_threshold,
  input  wire logic [LEVEL_BITS-1:0] level_cap,
  input  wire amr_cmd_t cmd,
  output amr_sts_t  sts,
  output logic [1:0] tag
);
  localparam int DW = DATA_WIDTH;
  localparam int EW = DW + 2;            // headroom for sums and magnitudes
  localparam int STEPS = DW + 1 + FRAC_BITS; // numerator bits plus shift
  localparam int CW = $clog2(STEPS + 1);
  localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  logic signed [DW-1:0] c_r, m_r [3], p_r [3];
  logic present_r, row_end_r, block_end_r;
  logic [LEVEL_BITS-1:0] level_r;
  logic [1:0] axis_r;
  logic [CW-1:0] cnt_r;
  logic [STEPS-1:0] num_r;   // shifting numerator bits
  logic [EW:0] rem_r;
  logic [EW-1:0] den_r;
  logic [DW:0] q_r;          // one extra bit catches saturation
  logic sat_r;
  logic signed [DW-1:0] meas_r, peak_r;
  logic [1:0] btag_r;

  function automatic logic signed [DW-1:0] sneg(input logic signed [DW-1:0] a);
    return (a == MINV) ? MAXV : -a;
  endfunction

  // per-axis operands
  logic signed [EW-1:0] ce, me, pe, avg, absc, absavg, numv;
  logic [EW-1:0] denv;
  logic [1:0] ndim_eff;
  logic [1:0] last_axis;
  always_comb begin
    ce = EW'(c_r);
    me = EW'(m_r[axis_r]);
    pe = EW'(p_r[axis_r]);
    avg = (me + pe) >>> 1;
    absc = ce[EW-1] ? -ce : ce;
    absavg = avg[EW-1] ? -avg : avg;
    if (mode == MODE_SECOND) begin
      numv = (avg > ce) ? avg - ce : ce - avg;
      denv = EW'(absavg + absc + EW'(1));
    end else begin
      numv = (pe > me) ? pe - me : me - pe;
      denv = EW'(absc + EW'(1));
    end
    ndim_eff = (ndim_used == 2'd0) ? 2'd1 : ndim_used;
    last_axis = ndim_eff - 2'd1;
  end

  // one restoring step; numerator is numv<<sh, sh = FRAC_BITS or FRAC_BITS-1
  logic [EW:0] rem_sh;
  logic [EW:0] rem_sub;
  logic [DW:0] q_nx;
  always_comb begin
    rem_sh = {rem_r[EW-1:0], num_r[STEPS-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    q_nx = {q_r[DW-1:0], ~rem_sub[EW]};
  end

  logic signed [DW-1:0] qval, cellm, rt, dt;
  logic [1:0] flag;
  always_comb begin
    // quotient at or above 2^(DW-1) does not fit the signed range
    qval = (sat_r || q_r[DW] || q_r[DW-1]) ? MAXV : q_r[DW-1:0];
    cellm = negate_magnitude ? sneg(c_r) : c_r;
    rt = refine_threshold;
    dt = derefine_threshold;
    if (negate_magnitude) begin
      rt = sneg(refine_threshold);
      dt = sneg(derefine_threshold);
    end
    flag = TAG_SAME;
  end

  logic signed [DW-1:0] peak_new, rt_use, dt_use;
  logic [1:0] rflag;
  always_comb begin
    peak_new = peak_r;
    if (present_r) begin
      if (mode[1]) begin
        if (cellm > peak_r) peak_new = cellm;
      end else if (meas_r > peak_r) peak_new = meas_r;
    end
    rt_use = mode[1] ? rt : refine_threshold;
    dt_use = mode[1] ? dt : derefine_threshold;
    rflag = flag;
    if (peak_new > rt_use && level_r < level_cap) rflag = TAG_REFINE;
    if (peak_new < dt_use) rflag = TAG_DEREFINE;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_r <= in_ch.center;
      m_r[0] <= in_ch.x_minus; p_r[0] <= in_ch.x_plus;
      m_r[1] <= in_ch.y_minus; p_r[1] <= in_ch.y_plus;
      m_r[2] <= in_ch.z_minus; p_r[2] <= in_ch.z_plus;
      present_r <= in_ch.var_present;
      level_r <= in_ch.block_level;
      row_end_r <= in_ch.row_last | in_ch.block_last;
      block_end_r <= in_ch.block_last;
      meas_r <= '0;
    end
    if (cmd.prep) begin
      num_r <= (mode == MODE_SECOND) ? STEPS'(numv[DW:0]) << FRAC_BITS
                                     : STEPS'(numv[DW:0]) << (FRAC_BITS - 1);
      den_r <= denv;
      rem_r <= '0;
      q_r <= '0;
      sat_r <= 1'b0;
    end
    if (cmd.div_step) begin
      num_r <= num_r << 1;
      q_r <= q_nx;
      sat_r <= sat_r | q_r[DW];
      rem_r <= rem_sub[EW] ? rem_sh : rem_sub;
    end
    if (cmd.axis_done && qval > meas_r) meas_r <= qval;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= '0; cnt_r <= '0; peak_r <= '0; btag_r <= TAG_DEREFINE;
    end else begin
      if (cmd.load) axis_r <= '0;
      if (cmd.axis_done) axis_r <= axis_r + 2'd1;
      if (cmd.prep) cnt_r <= '0;
      if (cmd.div_step) cnt_r <= cnt_r + CW'(1);
      if (cmd.classify) begin
        if (row_end_r) begin
          peak_r <= '0;
          if (rflag > btag_r) btag_r <= rflag;
        end else peak_r <= peak_new;
      end
      if (cmd.emit) btag_r <= TAG_DEREFINE;
    end
  end

  always_comb begin
    sts.div_last = (cnt_r == CW'(STEPS - 1));
    sts.axis_last = (axis_r == last_axis);
    sts.use_div = present_r && !mode[1];
    sts.block_end = block_end_r;
    tag = btag_r;
  end
endmodule
`default_nettype wire
